### design/pbbb_pkg.sv
// ----------------------------------------------------------------------------
// pbbb_pkg
// Shared types, constants and helpers of the per-bone bounding box core.
// ----------------------------------------------------------------------------
package pbbb_pkg;

  // Parameter defaults
  localparam int unsigned BonesDef        = 256;
  localparam int unsigned PaletteSlotsDef = 8;
  localparam int unsigned InfluencesDef   = 4;

  // Field widths
  localparam int unsigned CoordW   = 20;
  localparam int unsigned VtxW     = 16;
  localparam int unsigned InflW    = 16;
  localparam int unsigned NumInfl  = 4;
  localparam int unsigned InflSelW = 2;
  localparam int unsigned CountW   = 3;
  localparam int unsigned SlotByteW = 6;

  // Input tdata layout
  localparam int unsigned InIndexLo = 0;
  localparam int unsigned InAuxLo   = 8;
  localparam int unsigned InCoordLo = 16;
  localparam int unsigned InInflLo  = 76;
  localparam int unsigned InTdataW  = 144;

  // Output tdata layout
  localparam int unsigned BoxW      = 6 * CoordW;
  localparam int unsigned OutBadBit = BoxW;
  localparam int unsigned OutTdataW = 128;

  localparam logic [7:0] UnusedBone = 8'hff;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_VERTEX = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VERTEX,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One box entry as stored in the bounds memory
  typedef struct packed {
    logic signed [CoordW-1:0] hi_z;
    logic signed [CoordW-1:0] hi_y;
    logic signed [CoordW-1:0] hi_x;
    logic signed [CoordW-1:0] lo_z;
    logic signed [CoordW-1:0] lo_y;
    logic signed [CoordW-1:0] lo_x;
  } box_t;

  // Controller to datapath
  typedef struct packed {
    logic                capture;
    logic                issue;
    logic [InflSelW-1:0] inf_sel;
    logic                load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CountW-1:0] inf_count;
  } status_t;

  // Bring a vertex coordinate to Q16.4: low 16 bits as signed, scaled in large mode
  function automatic logic signed [CoordW-1:0] vtx_scale(
    input logic [CoordW-1:0] raw,
    input logic              large_en
  );
    logic [VtxW-1:0] v16;
    v16 = raw[VtxW-1:0];
    if (large_en) begin
      vtx_scale = {v16, 4'b0000};
    end else begin
      vtx_scale = {{(CoordW-VtxW){v16[VtxW-1]}}, v16};
    end
  endfunction

endpackage

### design/per_bone_bounding_box_core.sv
// Sequence: palette load, clear and box read go from accept to ST_DONE, then to the result;
// a vertex steps its influences in use in ST_VERTEX, then passes ST_DRAIN and ST_DONE.
// The core takes one item at a time; the next item is taken while a result waits.
// The vertex rate is set by the bounds memory, one influence update per cycle.
// Reset (rst_ni, async low): palette all unused, recorded marks cleared,
// large_mode 0, no result pending; bounds memory is not cleared.
// ----------------------------------------------------------------------------
// per_bone_bounding_box_core
// Per-bone axis-aligned boxes grown from skinned vertices, with a slot palette.
// ----------------------------------------------------------------------------
module per_bone_bounding_box_core #(
  parameter int unsigned BONES         = pbbb_pkg::BonesDef,
  parameter int unsigned PALETTE_SLOTS = pbbb_pkg::PaletteSlotsDef,
  parameter int unsigned INFLUENCES    = pbbb_pkg::InfluencesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: large_mode
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // index[7:0], aux[15:8], coord_x[35:16], coord_y[55:36], coord_z[75:56],
  // influence_0[91:76], influence_1[107:92], influence_2[123:108],
  // influence_3[139:124], zero fill
  input  logic [pbbb_pkg::InTdataW-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // min_x[19:0], min_y[39:20], min_z[59:40], max_x[79:60], max_y[99:80],
  // max_z[119:100], bad_slot[120], zero fill
  output logic [pbbb_pkg::OutTdataW-1:0] m_axis_tdata,
  // was_recorded
  output logic                           m_axis_tuser
);

  pbbb_pkg::cmd_t    cmd;
  pbbb_pkg::status_t status;
  pbbb_pkg::op_e     s_op;

  assign s_op        = pbbb_pkg::op_e'(s_axis_tuser);
  assign cfg_ready_o = 1'b1;

  pbbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_op_i     (s_op),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbbb_dp #(
    .BONES         (BONES),
    .PALETTE_SLOTS (PALETTE_SLOTS),
    .INFLUENCES    (INFLUENCES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .s_op_i      (s_op),
    .s_tdata_i   (s_axis_tdata),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // Busy after every accepted transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // A loaded result shows up on the output
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

  // No influence is stepped while an item is being captured
  a_issue_not_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.issue))
    else $error("influence issued during capture");
`endif

endmodule

### design/pbbb_ram.sv
// ----------------------------------------------------------------------------
// pbbb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pbbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/pbbb_ctrl.sv
// ----------------------------------------------------------------------------
// pbbb_ctrl
// Sequencer: accepts an item, steps the vertex influences one per cycle,
// drains the update stage and hands the result to the output register.
// ----------------------------------------------------------------------------
module pbbb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  pbbb_pkg::op_e        s_op_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  pbbb_pkg::status_t    status_i,
  output pbbb_pkg::cmd_t       cmd_o
);

  pbbb_pkg::state_e                    state_q, state_d;
  logic [pbbb_pkg::InflSelW-1:0]       k_q, k_d;
  logic                                out_valid_q, out_valid_d;
  logic [pbbb_pkg::CountW-1:0]         k_next;

  assign k_next = {1'b0, k_q} + pbbb_pkg::CountW'(1);

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbbb_pkg::ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      pbbb_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          k_d           = '0;
          if (s_op_i == pbbb_pkg::OP_VERTEX) begin
            state_d = pbbb_pkg::ST_VERTEX;
          end else begin
            state_d = pbbb_pkg::ST_DONE;
          end
        end
      end
      pbbb_pkg::ST_VERTEX: begin
        if (status_i.inf_count == '0) begin
          state_d = pbbb_pkg::ST_DRAIN;
        end else begin
          cmd_o.issue   = 1'b1;
          cmd_o.inf_sel = k_q;
          if (k_next == status_i.inf_count) begin
            state_d = pbbb_pkg::ST_DRAIN;
          end else begin
            k_d = k_next[pbbb_pkg::InflSelW-1:0];
          end
        end
      end
      pbbb_pkg::ST_DRAIN: begin
        state_d = pbbb_pkg::ST_DONE;
      end
      pbbb_pkg::ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = pbbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbbb_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

### design/pbbb_dp.sv
// ----------------------------------------------------------------------------
// pbbb_dp
// Datapath: palette, recorded marks, bounds memory with a two-stage
// read-modify-write pipeline, and the output register.
// ----------------------------------------------------------------------------
module pbbb_dp #(
  parameter int unsigned BONES         = pbbb_pkg::BonesDef,
  parameter int unsigned PALETTE_SLOTS = pbbb_pkg::PaletteSlotsDef,
  parameter int unsigned INFLUENCES    = pbbb_pkg::InfluencesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_data_i,
  input  pbbb_pkg::cmd_t                   cmd_i,
  output pbbb_pkg::status_t                status_o,
  input  pbbb_pkg::op_e                    s_op_i,
  input  logic [pbbb_pkg::InTdataW-1:0]    s_tdata_i,
  output logic [pbbb_pkg::OutTdataW-1:0]   m_tdata_o,
  output logic                             m_tuser_o
);

  localparam int unsigned BoneW = $clog2(BONES);
  localparam int unsigned SlotW = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
  localparam int unsigned CW    = pbbb_pkg::CoordW;

  // Input unpacking
  logic [7:0]                     in_index, in_aux;
  logic [CW-1:0]                  in_coord [3];
  logic [pbbb_pkg::InflW-1:0]     in_infl  [pbbb_pkg::NumInfl];

  always_comb begin
    in_index = s_tdata_i[pbbb_pkg::InIndexLo +: 8];
    in_aux   = s_tdata_i[pbbb_pkg::InAuxLo +: 8];
    for (int a = 0; a < 3; a++) begin
      in_coord[a] = s_tdata_i[pbbb_pkg::InCoordLo + a*CW +: CW];
    end
    for (int i = 0; i < pbbb_pkg::NumInfl; i++) begin
      in_infl[i] = s_tdata_i[pbbb_pkg::InInflLo + i*pbbb_pkg::InflW +: pbbb_pkg::InflW];
    end
  end

  // Registered item
  pbbb_pkg::op_e               op_q;
  logic [7:0]                  index_q, aux_q;
  logic [CW-1:0]               coord_q [3];
  logic [pbbb_pkg::InflW-1:0]  infl_q  [pbbb_pkg::NumInfl];

  // State
  logic                        large_mode_q;
  logic [7:0]                  palette_q [PALETTE_SLOTS];
  logic [BONES-1:0]            marks_q;
  logic                        bad_q;

  // Pipeline
  logic                        s1_valid_q;
  logic [BoneW-1:0]            s1_bone_q;
  logic                        wr_valid_q;
  logic [BoneW-1:0]            wr_bone_q;
  pbbb_pkg::box_t              wr_box_q;

  // Output register
  pbbb_pkg::box_t              out_box_q;
  logic                        out_rec_q, out_bad_q;

  // Memory ports
  logic                        ram_rd_en;
  logic [BoneW-1:0]            ram_rd_addr;
  logic [pbbb_pkg::BoxW-1:0]   ram_rd_data;
  pbbb_pkg::box_t              new_box;

  // Issue stage signals
  logic [pbbb_pkg::InflW-1:0]     inf;
  logic [7:0]                     weight;
  logic [pbbb_pkg::SlotByteW-1:0] slot;
  logic                           slot_ok;
  logic [7:0]                     bone;
  logic                           inf_use;
  logic                           read_ok;

  // Vertex in Q16.4
  logic signed [CW-1:0]        vtx [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vtx[a] = pbbb_pkg::vtx_scale(coord_q[a], large_mode_q);
    end
  end

  // Clamp the influence count
  assign status_o.inf_count = (aux_q > 8'(INFLUENCES)) ? pbbb_pkg::CountW'(INFLUENCES)
                                                       : aux_q[pbbb_pkg::CountW-1:0];

  // Decode the selected influence and look up its bone
  always_comb begin
    inf     = infl_q[cmd_i.inf_sel];
    weight  = inf[7:0];
    slot    = inf[15:10];
    slot_ok = {2'b00, slot} < 8'(PALETTE_SLOTS);
    bone    = palette_q[slot[SlotW-1:0]];
    inf_use = (weight != 8'd0) && slot_ok && (bone != pbbb_pkg::UnusedBone) &&
              ({1'b0, bone} < 9'(BONES));
  end

  assign read_ok = {1'b0, in_index} < 9'(BONES);

  // Memory read: box read at capture, or the bone of an issued influence
  always_comb begin
    if (cmd_i.issue) begin
      ram_rd_en   = inf_use;
      ram_rd_addr = bone[BoneW-1:0];
    end else begin
      ram_rd_en   = cmd_i.capture && (s_op_i == pbbb_pkg::OP_READ) && read_ok;
      ram_rd_addr = in_index[BoneW-1:0];
    end
  end

  // Update stage: forward the entry written last cycle, then widen or restart
  always_comb begin
    pbbb_pkg::box_t old_box;
    logic           rec;
    if (wr_valid_q && (wr_bone_q == s1_bone_q)) begin
      old_box = wr_box_q;
    end else begin
      old_box = pbbb_pkg::box_t'(ram_rd_data);
    end
    rec = marks_q[s1_bone_q];
    new_box.lo_x = (!rec || (vtx[0] < old_box.lo_x)) ? vtx[0] : old_box.lo_x;
    new_box.lo_y = (!rec || (vtx[1] < old_box.lo_y)) ? vtx[1] : old_box.lo_y;
    new_box.lo_z = (!rec || (vtx[2] < old_box.lo_z)) ? vtx[2] : old_box.lo_z;
    new_box.hi_x = (!rec || (vtx[0] > old_box.hi_x)) ? vtx[0] : old_box.hi_x;
    new_box.hi_y = (!rec || (vtx[1] > old_box.hi_y)) ? vtx[1] : old_box.hi_y;
    new_box.hi_z = (!rec || (vtx[2] > old_box.hi_z)) ? vtx[2] : old_box.hi_z;
  end

  pbbb_ram #(
    .WIDTH (pbbb_pkg::BoxW),
    .DEPTH (BONES)
  ) u_bounds (
    .clk_i     (clk_i),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_bone_q),
    .wr_data_i (new_box),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Control state: mode, palette, marks, flags, pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_mode_q <= 1'b0;
      for (int s = 0; s < PALETTE_SLOTS; s++) begin
        palette_q[s] <= pbbb_pkg::UnusedBone;
      end
      marks_q      <= '0;
      bad_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
      wr_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        large_mode_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        bad_q <= 1'b0;
        if ((s_op_i == pbbb_pkg::OP_LOAD) && (in_index < 8'(PALETTE_SLOTS))) begin
          palette_q[in_index[SlotW-1:0]] <= in_aux;
        end
        if (s_op_i == pbbb_pkg::OP_CLEAR) begin
          marks_q <= '0;
        end
      end
      if (cmd_i.issue && (weight != 8'd0) && !slot_ok) begin
        bad_q <= 1'b1;
      end
      if (s1_valid_q) begin
        marks_q[s1_bone_q] <= 1'b1;
      end
      s1_valid_q <= cmd_i.issue && inf_use;
      wr_valid_q <= s1_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= s_op_i;
      index_q <= in_index;
      aux_q   <= in_aux;
      coord_q <= in_coord;
      infl_q  <= in_infl;
    end
    s1_bone_q <= bone[BoneW-1:0];
    wr_bone_q <= s1_bone_q;
    wr_box_q  <= new_box;
  end

  // Result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_bad_q <= (op_q == pbbb_pkg::OP_VERTEX) && bad_q;
      if ((op_q == pbbb_pkg::OP_READ) && ({1'b0, index_q} < 9'(BONES)) &&
          marks_q[index_q[BoneW-1:0]]) begin
        out_box_q <= pbbb_pkg::box_t'(ram_rd_data);
        out_rec_q <= 1'b1;
      end else if (op_q == pbbb_pkg::OP_READ) begin
        out_box_q.lo_x <= coord_q[0];
        out_box_q.lo_y <= coord_q[1];
        out_box_q.lo_z <= coord_q[2];
        out_box_q.hi_x <= coord_q[0];
        out_box_q.hi_y <= coord_q[1];
        out_box_q.hi_z <= coord_q[2];
        out_rec_q      <= 1'b0;
      end else begin
        out_box_q <= '0;
        out_rec_q <= 1'b0;
      end
    end
  end

  assign m_tdata_o = {{(pbbb_pkg::OutTdataW - pbbb_pkg::BoxW - 1){1'b0}}, out_bad_q,
                      out_box_q.hi_z, out_box_q.hi_y, out_box_q.hi_x,
                      out_box_q.lo_z, out_box_q.lo_y, out_box_q.lo_x};
  assign m_tuser_o = out_rec_q;

endmodule

### verif/pbbb_box_check_pkg.sv
// ----------------------------------------------------------------------------
// pbbb_box_check_pkg
// Item types and the box scoreboard for the per-bone bounding box core:
// it mirrors the palette, bounds and marks and checks every output transfer.
// ----------------------------------------------------------------------------
package pbbb_box_check_pkg;
  import pbbb_pkg::*;

  // One input transfer, unpacked from tdata and tuser
  typedef struct packed {
    op_e                       op;
    logic [7:0]                index;
    logic [7:0]                aux;
    logic signed [CoordW-1:0]  coord_x;
    logic signed [CoordW-1:0]  coord_y;
    logic signed [CoordW-1:0]  coord_z;
    logic [NumInfl-1:0][InflW-1:0] infl;
  } bone_item_t;

  // One output transfer
  typedef struct packed {
    box_t box;
    logic recorded;
    logic bad_slot;
  } box_answer_t;

  class bone_box_board;
    logic [7:0]               palette [PaletteSlotsDef];
    logic signed [CoordW-1:0] lo_bound [BonesDef][3];
    logic signed [CoordW-1:0] hi_bound [BonesDef][3];
    bit                       recorded [BonesDef];
    bit                       large_mode;
    box_answer_t              awaited [$];
    int unsigned              mismatches;
    int unsigned              results_seen;

    function new();
      foreach (palette[i]) palette[i] = UnusedBone;
      foreach (recorded[b]) recorded[b] = 1'b0;
      large_mode   = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_mode(bit m);
      large_mode = m;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int unsigned failures();
      return mismatches;
    endfunction

    // Apply one accepted transfer to the mirrored state and queue its answer
    function void note_item(bone_item_t it);
      box_answer_t              ans;
      logic [CoordW-1:0]        raw [3];
      logic signed [CoordW-1:0] vtx [3];
      logic signed [VtxW-1:0]   v16;
      logic [7:0]               weight;
      logic [5:0]               slot;
      logic [7:0]               bone;
      int                       count;
      int                       a;
      int                       k;
      ans    = '0;
      raw[0] = it.coord_x;
      raw[1] = it.coord_y;
      raw[2] = it.coord_z;
      case (it.op)
        OP_LOAD: begin
          if (it.index < PaletteSlotsDef) palette[it.index] = it.aux;
        end
        OP_VERTEX: begin
          count = (it.aux > InfluencesDef) ? InfluencesDef : it.aux;
          // Take the low 16 bits as signed; whole units become Q16.4 in large mode
          for (a = 0; a < 3; a++) begin
            v16    = raw[a][VtxW-1:0];
            vtx[a] = v16;
            if (large_mode) vtx[a] = vtx[a] <<< 4;
          end
          for (k = 0; k < count; k++) begin
            weight = it.infl[k][7:0];
            slot   = it.infl[k][15:10];
            if (weight == 8'd0) continue;
            if (slot >= PaletteSlotsDef) begin
              ans.bad_slot = 1'b1;
              continue;
            end
            bone = palette[slot];
            if (bone == UnusedBone) continue;
            // Restart a box whose bone is not marked, else widen it
            for (a = 0; a < 3; a++) begin
              if (!recorded[bone]) begin
                lo_bound[bone][a] = vtx[a];
                hi_bound[bone][a] = vtx[a];
              end else begin
                if (vtx[a] < lo_bound[bone][a]) lo_bound[bone][a] = vtx[a];
                if (vtx[a] > hi_bound[bone][a]) hi_bound[bone][a] = vtx[a];
              end
            end
            recorded[bone] = 1'b1;
          end
        end
        OP_READ: begin
          if (recorded[it.index]) begin
            ans.recorded = 1'b1;
            ans.box.lo_x = lo_bound[it.index][0];
            ans.box.lo_y = lo_bound[it.index][1];
            ans.box.lo_z = lo_bound[it.index][2];
            ans.box.hi_x = hi_bound[it.index][0];
            ans.box.hi_y = hi_bound[it.index][1];
            ans.box.hi_z = hi_bound[it.index][2];
          end else begin
            // Unrecorded bone answers the skeleton center as a flat box
            ans.box.lo_x = it.coord_x;
            ans.box.lo_y = it.coord_y;
            ans.box.lo_z = it.coord_z;
            ans.box.hi_x = it.coord_x;
            ans.box.hi_y = it.coord_y;
            ans.box.hi_z = it.coord_z;
          end
        end
        OP_CLEAR: begin
          foreach (recorded[b]) recorded[b] = 1'b0;
        end
        default: ;
      endcase
      awaited.push_back(ans);
    endfunction

    function void cmp_field(string name, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
      end
    endfunction

    // Compare one output transfer with the oldest queued answer
    function void check_box(logic [OutTdataW-1:0] data, logic rec);
      box_answer_t want;
      box_answer_t got;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: output transfer with no answer queued, data %h",
                   results_seen, data);
        return;
      end
      want         = awaited.pop_front();
      got.box      = data[BoxW-1:0];
      got.bad_slot = data[OutBadBit];
      got.recorded = rec;
      cmp_field("min_x", want.box.lo_x, got.box.lo_x);
      cmp_field("min_y", want.box.lo_y, got.box.lo_y);
      cmp_field("min_z", want.box.lo_z, got.box.lo_z);
      cmp_field("max_x", want.box.hi_x, got.box.hi_x);
      cmp_field("max_y", want.box.hi_y, got.box.hi_y);
      cmp_field("max_z", want.box.hi_z, got.box.hi_z);
      cmp_field("was_recorded", CoordW'(want.recorded), CoordW'(got.recorded));
      cmp_field("bad_slot", CoordW'(want.bad_slot), CoordW'(got.bad_slot));
    endfunction
  endclass

endpackage

### verif/per_bone_bounding_box_core_test.sv
// ----------------------------------------------------------------------------
// per_bone_bounding_box_core_test
// Drives palette loads, skinned vertices, box reads and mark clears into the
// core in both coordinate modes, with random stalls on both streams, and
// checks every output transfer against a scoreboard that mirrors the state.
// ----------------------------------------------------------------------------
module per_bone_bounding_box_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbbb_pkg::*;
  import pbbb_box_check_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 400;
  localparam int unsigned PhaseCount  = 4;
  localparam int unsigned SettleTicks = 12;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i    = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  bone_box_board board = new();
  int unsigned   cycles     = 0;
  int unsigned   stall_left = 0;
  bit            quiet_run  = 1'b0;
  logic [7:0]    bone_pool [8];

  per_bone_bounding_box_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the output stream in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 6) == 0) begin
      stall_left    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_box(m_axis_tdata, m_axis_tuser);
  end

  function automatic bone_item_t mk_item(op_e op, logic [7:0] index, logic [7:0] aux,
                                         logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                                         logic [CoordW-1:0] cz, logic [63:0] infl);
    bone_item_t it;
    it.op      = op;
    it.index   = index;
    it.aux     = aux;
    it.coord_x = cx;
    it.coord_y = cy;
    it.coord_z = cz;
    it.infl    = infl;
    return it;
  endfunction

  // Hold the transfer until accepted; valid stays high for a following item
  task automatic send_item(input bone_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, it.infl, it.coord_z, it.coord_y, it.coord_x, it.aux, it.index};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(it);
  endtask

  task automatic idle_sender(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (!quiet_run && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 14));
  endtask

  // Hold off the sender until every queued answer has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_mode(m);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 20'h7FFFF;
      1:       return 20'h80000;
      2:       return {4'($urandom()), 16'h7FFF};
      3:       return {4'($urandom()), 16'h8000};
      default: return 20'($urandom());
    endcase
  endfunction

  // Mostly valid slots with weight, some zero weights and out-of-range slots
  function automatic logic [InflW-1:0] rand_infl();
    int unsigned r;
    logic [7:0]  slot_byte;
    logic [7:0]  weight;
    slot_byte = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 31)) : 8'($urandom());
    r = $urandom_range(0, 9);
    if (r < 8) weight = 8'($urandom_range(1, 255));
    else if (r == 8) weight = 8'd0;
    else weight = 8'($urandom());
    return {slot_byte, weight};
  endfunction

  function automatic bone_item_t rand_item();
    int unsigned r;
    logic [7:0]  index;
    logic [7:0]  aux;
    op_e         op;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      op    = OP_LOAD;
      index = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom());
      aux   = ($urandom_range(0, 99) < 85) ? bone_pool[$urandom_range(0, 7)] : UnusedBone;
    end else if (r < 62) begin
      op    = OP_VERTEX;
      index = 8'($urandom());
      aux   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 4)) : 8'($urandom());
    end else if (r < 97) begin
      op    = OP_READ;
      index = ($urandom_range(0, 9) < 7) ? bone_pool[$urandom_range(0, 7)] : 8'($urandom());
      aux   = 8'($urandom());
    end else begin
      op    = OP_CLEAR;
      index = 8'($urandom());
      aux   = 8'($urandom());
    end
    return mk_item(op, index, aux, rand_coord(), rand_coord(), rand_coord(),
                   {rand_infl(), rand_infl(), rand_infl(), rand_infl()});
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, normal mode
    write_mode(1'b0);
    send_item(mk_item(OP_READ, 8'd5, 8'd0, 20'h7FFFF, 20'h80000, 20'h00000, 64'd0));
    send_item(mk_item(OP_LOAD, 8'd0, 8'd5, '0, '0, '0, 64'd0));
    send_item(mk_item(OP_LOAD, 8'd1, 8'd0, '0, '0, '0, 64'd0));
    maybe_idle();
    send_item(mk_item(OP_LOAD, 8'd7, 8'd254, '0, '0, '0, 64'd0));
    // Slot out of range on load: ignored
    send_item(mk_item(OP_LOAD, 8'd8, 8'd9, '0, '0, '0, 64'd0));
    send_item(mk_item(OP_LOAD, 8'd255, 8'd77, '0, '0, '0, 64'd0));
    send_item(mk_item(OP_LOAD, 8'd2, UnusedBone, '0, '0, '0, 64'd0));
    // Four influences: two bones, an unused palette entry, top slot
    send_item(mk_item(OP_VERTEX, 8'd0, 8'd4, 20'hF7FFF, 20'h08000, 20'h00000,
                      {8'd31, 8'h80, 8'd8, 8'd9, 8'd7, 8'd1, 8'd0, 8'd255}));
    // Bad slot, zero weight, influence beyond the count
    send_item(mk_item(OP_VERTEX, 8'hFF, 8'd2, 20'h0FFFF, 20'h00001, 20'hFFFFF,
                      {16'd0, 8'd0, 8'd50, 8'd3, 8'd0, 8'd32, 8'd1}));
    maybe_idle();
    // No influences in use
    send_item(mk_item(OP_VERTEX, 8'd0, 8'd0, 20'h12345, 20'h54321, 20'h0ABCD,
                      {8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd1}));
    // Count above four, bad slot byte, unused slot
    send_item(mk_item(OP_VERTEX, 8'd0, 8'd255, 20'h08000, 20'h08000, 20'h08000,
                      {8'd12, 8'd7, 8'd28, 8'd1, 8'd4, 8'd3, 8'hFF, 8'hFF}));
    send_item(mk_item(OP_READ, 8'd5, 8'd0, 20'h11111, 20'h22222, 20'h33333, 64'd0));
    send_item(mk_item(OP_READ, 8'd0, 8'd0, 20'h44444, 20'h55555, 20'h66666, 64'd0));
    send_item(mk_item(OP_READ, 8'd254, 8'd255, '0, '0, '0, 64'd0));
    send_item(mk_item(OP_READ, 8'd255, 8'd0, 20'h80000, 20'h7FFFF, 20'hFFFFF, 64'd0));
    send_item(mk_item(OP_READ, 8'd9, 8'd0, 20'h00010, 20'hFFFF0, 20'h7FFFF, 64'd0));
    // Clear marks, then the next influence restarts the box
    send_item(mk_item(OP_CLEAR, 8'hFF, 8'hFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, '1));
    send_item(mk_item(OP_READ, 8'd5, 8'd0, 20'h00100, 20'h00200, 20'h00300, 64'd0));
    send_item(mk_item(OP_VERTEX, 8'd0, 8'd1, 20'h00003, 20'hFFFFD, 20'h00007,
                      {48'd0, 8'd0, 8'd1}));
    send_item(mk_item(OP_READ, 8'd5, 8'd0, '0, '0, '0, 64'd0));

    // Directed part, large mode
    write_mode(1'b1);
    send_item(mk_item(OP_VERTEX, 8'd0, 8'd1, 20'h07FFF, 20'h08000, 20'h0FFFF,
                      {48'd0, 8'd3, 8'd200}));
    send_item(mk_item(OP_VERTEX, 8'd0, 8'd3, 20'h00001, 20'hF0000, 20'h7FFFF,
                      {16'd0, 8'd0, 8'd4, 8'd4, 8'd9, 8'd1, 8'd128}));
    send_item(mk_item(OP_READ, 8'd5, 8'd0, '0, '0, '0, 64'd0));
    send_item(mk_item(OP_READ, 8'd0, 8'd0, '0, '0, '0, 64'd0));

    // Random phases, alternating coordinate modes; the last one runs without idling
    for (int p = 0; p < PhaseCount; p++) begin
      write_mode(p[0] == 1'b0);
      foreach (bone_pool[i]) bone_pool[i] = 8'($urandom());
      quiet_run = (p == PhaseCount - 1);
      for (int i = 0; i < PhaseItems; i++) begin
        send_item(rand_item());
        if (!quiet_run && $urandom_range(0, 149) == 0) drain();
        else maybe_idle();
      end
    end

    // Wait out the last answers, then report
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SettleTicks) @(posedge clk_i);
    if (board.failures() == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
